// ----- design/line_sensor_position_and_node_macros.svh -----
// assertion macros for the line sensor block
`ifndef LINE_SENSOR_POSITION_AND_NODE_MACROS_SVH
`define LINE_SENSOR_POSITION_AND_NODE_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define LSP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// next-cycle implication checked outside reset
`define LSP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

// ----- design/lsp_pkg.sv -----
// shared types and constants for the line sensor block
package lsp_pkg;
  localparam int NSENS = 6;
  localparam int FRAC_BITS = 16;
  localparam int LOST_SUM_LIMIT = 6554;
  localparam int RAW_W = 10;
  localparam int LVL_W = 17;
  localparam int CFG_W = 27;
  localparam int CFG_IDX_W = 3;
  localparam int SUM_W = 20;
  localparam int WSUM_W = 24;
  localparam int DIV_W = 36;
  localparam int POS_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_THRESH = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD = 3'd7;
  localparam logic [LVL_W-1:0] THRESH_RESET = 17'd16384;
  localparam logic [15:0] HOLD_RESET = 16'd15;

  // sensor weight for lane j: 2*j - 5
  function automatic logic signed [3:0] sensor_weight(input int j);
    sensor_weight = 4'(2 * j - 5);
  endfunction

  typedef struct packed {
    logic start;
    logic busy;
  } div_ctrl_t;
endpackage

// ----- design/lsp_if.sv -----
// valid/ready channel carrying a request or result payload
interface lsp_if #(parameter int W = 8);
  logic valid;
  logic ready;
  logic [W-1:0] data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ----- design/lsp_lane.sv -----
// one sensor lane: calibrate a raw sample into a clamped level
module lsp_lane (
  input  logic clk,
  input  logic load,
  input  logic [lsp_pkg::RAW_W-1:0] raw,
  input  logic [lsp_pkg::CFG_W-1:0] cal,
  output logic [lsp_pkg::LVL_W-1:0] level
);
  logic [lsp_pkg::RAW_W-1:0] white;
  logic [16:0] recip;
  logic [26:0] prod;
  logic [lsp_pkg::LVL_W-1:0] level_r;
  logic [lsp_pkg::LVL_W-1:0] level_nxt;

  assign white = cal[9:0];
  assign recip = cal[26:10];
  assign prod = 27'(white - raw) * 27'(recip);

  // clamp to one, zero when raw reaches white
  always_comb begin
    if (raw >= white) level_nxt = '0;
    else if (prod > 27'(1 << lsp_pkg::FRAC_BITS)) level_nxt = 17'(1 << lsp_pkg::FRAC_BITS);
    else level_nxt = prod[16:0];
  end

  always_ff @(posedge clk) begin
    if (load) level_r <= level_nxt;
  end
  assign level = level_r;
endmodule

// ----- design/lsp_div.sv -----
// restoring divider, one quotient bit per cycle, truncates the quotient
module lsp_div (
  input  logic clk,
  input  logic rst_n,
  input  lsp_pkg::div_ctrl_t ctrl_in,
  input  logic [lsp_pkg::DIV_W-1:0] dividend,
  input  logic [lsp_pkg::SUM_W-1:0] divisor,
  output logic busy,
  output logic [lsp_pkg::POS_W-1:0] quot
);
  localparam int CNT_W = $clog2(lsp_pkg::DIV_W + 1);
  logic [lsp_pkg::DIV_W-1:0] q_r, q_nxt;
  logic [lsp_pkg::SUM_W:0] rem_r, rem_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [lsp_pkg::SUM_W:0] trial;

  assign trial = {rem_r[lsp_pkg::SUM_W-1:0], q_r[lsp_pkg::DIV_W-1]};

  // shift in one dividend bit, subtract when it fits
  always_comb begin
    q_nxt = q_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    if (ctrl_in.start) begin
      q_nxt = dividend;
      rem_nxt = '0;
      cnt_nxt = CNT_W'(lsp_pkg::DIV_W);
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - 1'b1;
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = trial - {1'b0, divisor};
        q_nxt = {q_r[lsp_pkg::DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt = {q_r[lsp_pkg::DIV_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    rem_r <= rem_nxt;
  end

  assign busy = (cnt_r != '0);
  assign quot = q_r[lsp_pkg::POS_W-1:0];
endmodule

// ----- design/lsp_merge.sv -----
// merging stage: mask, sums, node tracking, centroid divide
module lsp_merge #(
  parameter int LOST_LIMIT = lsp_pkg::LOST_SUM_LIMIT
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic [lsp_pkg::LVL_W-1:0] levels [lsp_pkg::NSENS],
  input  logic [31:0] tick,
  input  logic [lsp_pkg::LVL_W-1:0] thresh,
  input  logic [15:0] hold,
  output logic done,
  output logic [lsp_pkg::NSENS-1:0] mask,
  output logic [lsp_pkg::POS_W-1:0] position,
  output logic lost,
  output logic found
);
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001, ST_SUM = 3'b010, ST_DIV = 3'b100
  } mst_t;
  mst_t st_r, st_nxt;
  logic node_pending_r, node_pending_nxt;
  logic [31:0] node_start_r, node_start_nxt;
  logic [lsp_pkg::NSENS-1:0] mask_r, mask_nxt;
  logic lost_r, lost_nxt, found_r, found_nxt, neg_r, neg_nxt;
  logic [lsp_pkg::SUM_W-1:0] sum_r, sum_nxt;
  logic signed [lsp_pkg::WSUM_W-1:0] wsum;
  logic [lsp_pkg::WSUM_W-1:0] mag;
  logic [lsp_pkg::DIV_W-1:0] dividend_r, dividend_nxt;
  logic [2:0] cnt;
  logic off;
  logic div_busy, div_busy_d_r;
  logic [lsp_pkg::POS_W-1:0] quot;
  lsp_pkg::div_ctrl_t dctl;

  // lane sums, weighted sum, mask, lost flag and rounded dividend
  always_comb begin
    sum_nxt = '0;
    wsum = '0;
    mask_nxt = '0;
    for (int j = 0; j < lsp_pkg::NSENS; j++) begin
      sum_nxt = sum_nxt + lsp_pkg::SUM_W'(levels[j]);
      wsum = wsum + lsp_pkg::WSUM_W'($signed({1'b0, levels[j]}))
           * lsp_pkg::WSUM_W'(lsp_pkg::sensor_weight(j));
      mask_nxt[j] = levels[j] > thresh;
    end
    mag = wsum[lsp_pkg::WSUM_W-1] ? lsp_pkg::WSUM_W'(-wsum) : lsp_pkg::WSUM_W'(wsum);
    neg_nxt = wsum[lsp_pkg::WSUM_W-1];
    lost_nxt = sum_nxt <= lsp_pkg::SUM_W'(LOST_LIMIT);
    dividend_nxt = {mag, 12'd0} + lsp_pkg::DIV_W'(sum_nxt >> 1);
  end

  // off-pattern test over the new mask
  always_comb begin
    cnt = 3'(mask_nxt[1]) + 3'(mask_nxt[2]) + 3'(mask_nxt[3]) + 3'(mask_nxt[4])
        + 3'(mask_nxt[5]);
    off = (cnt == 3'd0) || (cnt > 3'd3) || mask_nxt[5] || mask_nxt[0];
  end

  // node tracking and sequencing
  always_comb begin
    st_nxt = st_r;
    node_pending_nxt = node_pending_r;
    node_start_nxt = node_start_r;
    found_nxt = found_r;
    dctl.start = 1'b0;
    dctl.busy = div_busy;
    unique case (st_r)
      ST_IDLE: if (start) st_nxt = ST_SUM;
      ST_SUM: begin
        found_nxt = 1'b0;
        if (off) begin
          if (node_pending_r) found_nxt = (tick - node_start_r) > 32'(hold);
          else begin
            node_pending_nxt = 1'b1;
            node_start_nxt = tick;
          end
        end else begin
          node_pending_nxt = 1'b0;
          node_start_nxt = '0;
        end
        dctl.start = 1'b1;
        st_nxt = ST_DIV;
      end
      ST_DIV: if (!div_busy && div_busy_d_r) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      node_pending_r <= 1'b0;
      node_start_r <= '0;
      div_busy_d_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      node_pending_r <= node_pending_nxt;
      node_start_r <= node_start_nxt;
      div_busy_d_r <= div_busy;
    end
    found_r <= found_nxt;
    if (st_r == ST_SUM) begin
      mask_r <= mask_nxt;
      sum_r <= sum_nxt;
      lost_r <= lost_nxt;
      neg_r <= neg_nxt;
      dividend_r <= dividend_nxt;
    end
  end

  lsp_div u_div (
    .clk(clk), .rst_n(rst_n), .ctrl_in(dctl),
    .dividend(dctl.start ? dividend_nxt : dividend_r),
    .divisor(dctl.start ? sum_nxt : sum_r),
    .busy(div_busy), .quot(quot)
  );

  assign done = (st_r == ST_DIV) && !div_busy && div_busy_d_r;
  assign mask = mask_r;
  assign lost = lost_r;
  assign found = found_r;
  assign position = lost_r ? '0 : (neg_r ? lsp_pkg::POS_W'(-quot) : quot);
endmodule

// ----- design/line_sensor_position_and_node.sv -----
// Request path: the lane load and start registers, the idle and sum states, the divide steps,
// then the output register.
// Requests are handled one at a time, until the bit-serial centroid divider has finished.
// A new request waits until the previous result has been taken from the output register.
// Reset: synchronous active-low rst_n clears control, node state and registers
// to their documented reset values (calibration 0, threshold 0.25, hold 15).
module line_sensor_position_and_node #(
  parameter int LOST_LIMIT = lsp_pkg::LOST_SUM_LIMIT
) (
  input  logic clk,
  input  logic rst_n,
  lsp_if.sink   in_ch,
  lsp_if.source out_ch,
  input  logic cfg_we,
  input  logic [lsp_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [lsp_pkg::CFG_W-1:0] cfg_wdata
);
  `include "line_sensor_position_and_node_macros.svh"
  localparam int OUT_W = 6 * lsp_pkg::LVL_W + 6 + 16 + 2;

  logic [lsp_pkg::CFG_W-1:0] cal_r [lsp_pkg::NSENS];
  logic [lsp_pkg::LVL_W-1:0] thresh_r;
  logic [15:0] hold_r;
  logic busy_r, busy_nxt, load_d_r;
  logic [31:0] tick_r;
  logic [lsp_pkg::LVL_W-1:0] levels [lsp_pkg::NSENS];
  logic done, lost, found;
  logic [5:0] mask;
  logic [15:0] position;
  logic out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0] out_data_r;
  logic accept;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < lsp_pkg::NSENS; j++) cal_r[j] <= '0;
      thresh_r <= lsp_pkg::THRESH_RESET;
      hold_r <= lsp_pkg::HOLD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        lsp_pkg::REG_THRESH: thresh_r <= cfg_wdata[lsp_pkg::LVL_W-1:0];
        lsp_pkg::REG_HOLD: hold_r <= cfg_wdata[15:0];
        default: cal_r[cfg_idx] <= cfg_wdata;
      endcase
    end
  end

  // input request acceptance
  assign in_ch.ready = !busy_r && !load_d_r && !out_valid_r;
  assign accept = in_ch.valid && in_ch.ready;

  always_comb begin
    busy_nxt = busy_r;
    if (accept) busy_nxt = 1'b1;
    else if (done) busy_nxt = 1'b0;
    out_valid_nxt = out_valid_r;
    if (out_ch.valid && out_ch.ready) out_valid_nxt = 1'b0;
    if (done) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      load_d_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      load_d_r <= accept;
      out_valid_r <= out_valid_nxt;
    end
    if (accept) tick_r <= in_ch.data[91:60];
    if (done) out_data_r <= {found, lost, position, mask, levels[5], levels[4],
                             levels[3], levels[2], levels[1], levels[0]};
  end

  // calibration lanes
  for (genvar g = 0; g < lsp_pkg::NSENS; g++) begin : g_lane
    lsp_lane u_lane (
      .clk(clk), .load(accept),
      .raw(in_ch.data[g*lsp_pkg::RAW_W +: lsp_pkg::RAW_W]),
      .cal(cal_r[g]), .level(levels[g])
    );
  end

  lsp_merge #(.LOST_LIMIT(LOST_LIMIT)) u_merge (
    .clk(clk), .rst_n(rst_n), .start(load_d_r), .levels(levels), .tick(tick_r),
    .thresh(thresh_r), .hold(hold_r), .done(done), .mask(mask),
    .position(position), .lost(lost), .found(found)
  );

  assign out_ch.valid = out_valid_r;
  assign out_ch.data = out_data_r;

  `LSP_ASSERT_IMPL(a_no_accept_busy, clk, rst_n, busy_r, !in_ch.ready, "accepted while busy")
  `LSP_ASSERT_NEXT(a_done_sets_valid, clk, rst_n, done, out_valid_r, "result lost")
  `LSP_ASSERT_IMPL(a_done_only_busy, clk, rst_n, done, busy_r, "result without request")
endmodule

// ----- test/tb_top.sv -----
// testbench for the line sensor block: scans through a position and node predictor
`timescale 1ns / 1ps

module tb_top;
  localparam int HALF_NS = 2;
  localparam int LATENCY = 40;

  typedef struct packed {
    logic [31:0] tick;
    logic [lsp_pkg::NSENS-1:0][lsp_pkg::RAW_W-1:0] sample;
  } scan_t;

  typedef struct packed {
    logic node_found;
    logic line_lost;
    logic signed [lsp_pkg::POS_W-1:0] line_position;
    logic [lsp_pkg::NSENS-1:0] line_mask;
    logic [lsp_pkg::NSENS-1:0][lsp_pkg::LVL_W-1:0] level;
  } scan_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [lsp_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
  logic [lsp_pkg::CFG_W-1:0] cfg_wdata = '0;

  lsp_if #(.W($bits(scan_t))) in_ch ();
  lsp_if #(.W($bits(scan_result_t))) out_ch ();

  line_sensor_position_and_node u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  always #(HALF_NS) clk = ~clk;

  // predictor copy of registers and node state
  logic [lsp_pkg::CFG_W-1:0] cal_copy [lsp_pkg::NSENS];
  logic [lsp_pkg::LVL_W-1:0] thresh_copy;
  logic [15:0] hold_copy;
  logic pending_copy;
  logic [31:0] start_tick_copy;

  scan_result_t pending_results[$];
  int n_errors = 0;
  logic [31:0] tick_now = 0;

  // expected result of one scan, updates the node state
  function automatic scan_result_t predict_scan(scan_t s);
    scan_result_t r;
    longint lsum, wsum, mag, q, d, v;
    int cnt;
    logic off;
    lsum = 0;
    wsum = 0;
    r = '0;
    for (int j = 0; j < lsp_pkg::NSENS; j++) begin
      d = longint'(cal_copy[j][9:0]) - longint'(s.sample[j]);
      v = (d <= 0) ? 0 : d * longint'(cal_copy[j][26:10]);
      if (v > (64'sd1 <<< lsp_pkg::FRAC_BITS)) v = 64'sd1 <<< lsp_pkg::FRAC_BITS;
      r.level[j] = v[lsp_pkg::LVL_W-1:0];
      lsum += v;
      wsum += v * (2 * j - 5);
      if (v > longint'(thresh_copy)) r.line_mask[j] = 1'b1;
    end
    cnt = 0;
    for (int b = 1; b < lsp_pkg::NSENS; b++) cnt += r.line_mask[b];
    off = (cnt == 0) || (cnt > 3) || r.line_mask[0] || r.line_mask[5];
    // node tracking
    if (off) begin
      if (pending_copy) begin
        if ((s.tick - start_tick_copy) > {16'd0, hold_copy}) r.node_found = 1'b1;
      end else begin
        pending_copy = 1'b1;
        start_tick_copy = s.tick;
      end
    end else begin
      pending_copy = 1'b0;
      start_tick_copy = '0;
    end
    r.line_lost = (lsum <= lsp_pkg::LOST_SUM_LIMIT);
    if (!r.line_lost && lsum != 0) begin
      mag = (wsum < 0 ? -wsum : wsum) * 4096;
      q = (mag + lsum / 2) / lsum;
      r.line_position = (wsum < 0) ? lsp_pkg::POS_W'(-q) : lsp_pkg::POS_W'(q);
    end
    return r;
  endfunction

  // result channel: random stalls, compare each accepted result
  initial begin
    int n;
    out_ch.ready = 1'b0;
    forever begin
      n = (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13));
      repeat (n) @(negedge clk) out_ch.ready = 1'b0;
      @(negedge clk) out_ch.ready = 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
    end
  end

  always @(posedge clk) begin
    scan_result_t got, exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (pending_results.size() == 0) begin
        $error("result with no pending request");
        n_errors++;
      end else begin
        exp_r = pending_results.pop_front();
        for (int j = 0; j < lsp_pkg::NSENS; j++)
          if (got.level[j] !== exp_r.level[j]) begin
            $error("level_%0d: expected %0d, got %0d", j, exp_r.level[j], got.level[j]);
            n_errors++;
          end
        if (got.line_mask !== exp_r.line_mask) begin
          $error("line_mask: expected %h, got %h", exp_r.line_mask, got.line_mask);
          n_errors++;
        end
        if (got.line_position !== exp_r.line_position) begin
          $error("line_position: expected %0d, got %0d", exp_r.line_position,
                 got.line_position);
          n_errors++;
        end
        if (got.line_lost !== exp_r.line_lost) begin
          $error("line_lost: expected %0b, got %0b", exp_r.line_lost, got.line_lost);
          n_errors++;
        end
        if (got.node_found !== exp_r.node_found) begin
          $error("node_found: expected %0b, got %0b", exp_r.node_found, got.node_found);
          n_errors++;
        end
      end
    end
  end

  // send one scan request after a random gap
  task automatic send_scan(scan_t s, bit no_gap = 0);
    int gap;
    gap = (no_gap || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
    repeat (gap) @(negedge clk) in_ch.valid = 1'b0;
    @(negedge clk);
    in_ch.valid = 1'b1;
    in_ch.data = s;
    do @(posedge clk); while (!in_ch.ready);
    pending_results.push_back(predict_scan(s));
  endtask

  task automatic wait_drained();
    @(negedge clk) in_ch.valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic write_reg(logic [lsp_pkg::CFG_IDX_W-1:0] idx, logic [lsp_pkg::CFG_W-1:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_wdata = val;
    if (idx < lsp_pkg::NSENS) cal_copy[idx] = val;
    else if (idx == lsp_pkg::REG_THRESH) thresh_copy = val[lsp_pkg::LVL_W-1:0];
    else hold_copy = val[15:0];
    @(negedge clk) cfg_we = 1'b0;
  endtask

  function automatic scan_t random_scan();
    scan_t s;
    for (int j = 0; j < lsp_pkg::NSENS; j++)
      s.sample[j] = lsp_pkg::RAW_W'($urandom_range(0, 1023));
    // ticks mostly advance slowly so hold windows are crossed, sometimes jump
    if ($urandom_range(0, 19) == 0) tick_now = $urandom();
    else tick_now += $urandom_range(0, 9);
    s.tick = tick_now;
    return s;
  endfunction

  // realistic calibration: white near top, span gives full scale mid range
  task automatic random_calibration();
    logic [9:0] white;
    logic [16:0] recip;
    for (int j = 0; j < lsp_pkg::NSENS; j++) begin
      white = 10'($urandom_range(0, 9) == 0 ? $urandom_range(0, 1023)
                                            : $urandom_range(700, 1023));
      case ($urandom_range(0, 9))
        0: recip = 17'd0;
        1: recip = 17'($urandom());
        default: recip = 17'($urandom_range(60, 400));
      endcase
      write_reg(j[lsp_pkg::CFG_IDX_W-1:0], {recip, white});
    end
    write_reg(lsp_pkg::REG_THRESH, lsp_pkg::CFG_W'($urandom_range(0, 9) == 0 ? $urandom()
                                                   : $urandom_range(0, 65536)));
    write_reg(lsp_pkg::REG_HOLD, lsp_pkg::CFG_W'($urandom_range(0, 9) == 0 ? $urandom()
                                                 : $urandom_range(0, 40)));
  endtask

  task automatic test_reset_defaults();
    scan_t s;
    // reset calibration is zero: every level 0, line lost, mask off-pattern
    for (int i = 0; i < 3; i++) begin
      s = '0;
      s.tick = i * 10;
      send_scan(s);
    end
    wait_drained();
  endtask

  task automatic test_extremes();
    scan_t s;
    // full scale calibration on every sensor, threshold zero, hold zero
    for (int j = 0; j < lsp_pkg::NSENS; j++)
      write_reg(j[lsp_pkg::CFG_IDX_W-1:0], {lsp_pkg::CFG_W{1'b1}});
    write_reg(lsp_pkg::REG_THRESH, '0);
    write_reg(lsp_pkg::REG_HOLD, '0);
    s = '0;
    s.tick = 32'hFFFF_FFFE;
    send_scan(s);
    s.tick = 32'h0000_0003;
    send_scan(s);
    for (int j = 0; j < lsp_pkg::NSENS; j++) s.sample[j] = 10'h3FF;
    send_scan(s);
    // single sensor lit at each lane: position extremes
    for (int j = 0; j < lsp_pkg::NSENS; j++) begin
      s.sample = {lsp_pkg::NSENS{10'h3FF}};
      s.sample[j] = 10'd0;
      s.tick = 32'h100 + j;
      send_scan(s);
    end
    wait_drained();
    // threshold above one, longest hold, zero span on some sensors
    write_reg(lsp_pkg::REG_THRESH, 27'h1FFFF);
    write_reg(lsp_pkg::REG_HOLD, 27'hFFFF);
    write_reg(3'd2, {17'd0, 10'd1023});
    write_reg(3'd3, {17'd1, 10'd0});
    for (int i = 0; i < 6; i++) begin
      s = random_scan();
      s.tick = i[0] ? 32'h0001_0000 : 32'h0;
      send_scan(s);
    end
    wait_drained();
    // on-pattern center line with moderate threshold, then an all-lit off pattern
    write_reg(lsp_pkg::REG_THRESH, 27'd16384);
    write_reg(lsp_pkg::REG_HOLD, 27'd3);
    for (int j = 0; j < lsp_pkg::NSENS; j++)
      write_reg(j[lsp_pkg::CFG_IDX_W-1:0], {17'd200, 10'd900});
    for (int i = 0; i < 8; i++) begin
      s.sample = {10'd900, 10'd900, 10'd500, 10'd500, 10'd900, 10'd900};
      if (i >= 4) s.sample = {lsp_pkg::NSENS{10'd0}};
      s.tick = 32'd50 + 2 * i;
      send_scan(s);
    end
    wait_drained();
  endtask

  task automatic test_random_phases();
    for (int p = 0; p < 10; p++) begin
      random_calibration();
      for (int i = 0; i < 60; i++) send_scan(random_scan(), p == 9);
      wait_drained();
    end
  endtask

  task automatic test_drain_pause();
    random_calibration();
    for (int i = 0; i < 30; i++) begin
      send_scan(random_scan());
      if (i == 15) wait_drained();
    end
    wait_drained();
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    for (int j = 0; j < lsp_pkg::NSENS; j++) cal_copy[j] = '0;
    thresh_copy = lsp_pkg::THRESH_RESET;
    hold_copy = lsp_pkg::HOLD_RESET;
    pending_copy = 1'b0;
    start_tick_copy = '0;
    repeat (8) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;
    test_reset_defaults();
    test_extremes();
    test_random_phases();
    test_drain_pause();
    if (n_errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #5ms;
    $display("status: fail");
    $finish;
  end
endmodule
